FILE: rtl/core/sl10c_pkg.sv
// Shared types and constants for the scaled log10 converter.
// No dependencies; imported by sl10c_log2_pipe and scaled_log10_converter.
`timescale 1ns / 1ps

package sl10c_pkg;

  localparam int DATA_W    = 32;
  localparam int LOG2_FRAC = 28;
  localparam int POS_W     = 5;
  localparam int EXP_W     = 6;

  localparam logic signed [29:0] LOG10_OF_2_Q30 = 30'sd323228497;

  localparam logic [DATA_W-1:0] RESULT_MAX = 32'h7fff_ffff;
  localparam logic [DATA_W-1:0] RESULT_MIN = 32'h8000_0000;

  typedef enum logic {
    REG_LOG_SCALE  = 1'b0,
    REG_LOG_OFFSET = 1'b1
  } sl10c_reg_t;

  typedef struct packed {
    logic vld;
    logic zero;
    logic last;
  } sl10c_tag_t;

  typedef struct packed {
    logic [DATA_W-1:0] data;
    logic              zero;
    logic              ovf;
    logic              last;
  } sl10c_res_t;

endpackage

FILE: rtl/core/sl10c_log2_pipe.sv
// Pipelined base-two logarithm: leading-one normalise, then one squaring per stage.
// Depends on sl10c_pkg; instantiated by scaled_log10_converter.
`timescale 1ns / 1ps

module sl10c_log2_pipe
  import sl10c_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 en,
  input  sl10c_tag_t           in_tag,
  input  logic [DATA_W-1:0]    in_x,
  output sl10c_tag_t           out_tag,
  output logic [POS_W-1:0]     out_pos,
  output logic [LOG2_FRAC-1:0] out_frac
);

  sl10c_tag_t           tag_r  [0:LOG2_FRAC];
  logic [DATA_W-1:0]    m_r    [0:LOG2_FRAC];
  logic [POS_W-1:0]     pos_r  [0:LOG2_FRAC];
  logic [LOG2_FRAC-1:0] frac_r [0:LOG2_FRAC];

  logic [POS_W-1:0]  pos_nxt;
  logic [DATA_W-1:0] m_nxt;

  always_comb begin
    pos_nxt = '0;
    for (int k = 0; k < DATA_W; k++) begin
      if (in_x[k]) begin
        pos_nxt = POS_W'(k);
      end
    end
    m_nxt = in_x << (POS_W'(DATA_W - 1) - pos_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag_r[0] <= '0;
    end else if (en) begin
      tag_r[0] <= in_tag;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_r[0]    <= m_nxt;
      pos_r[0]  <= pos_nxt;
      frac_r[0] <= '0;
    end
  end

  for (genvar i = 0; i < LOG2_FRAC; i++) begin : g_sq
    logic [2*DATA_W-1:0] sq;
    logic [DATA_W:0]     sq_hi;
    logic                hit;
    logic [DATA_W-1:0]   m_sq_nxt;

    assign sq       = m_r[i] * m_r[i];
    assign sq_hi    = sq[2*DATA_W-1:DATA_W-1];
    assign hit      = sq_hi[DATA_W];
    assign m_sq_nxt = hit ? sq_hi[DATA_W:1] : sq_hi[DATA_W-1:0];

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        tag_r[i+1] <= '0;
      end else if (en) begin
        tag_r[i+1] <= tag_r[i];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        m_r[i+1]    <= m_sq_nxt;
        pos_r[i+1]  <= pos_r[i];
        frac_r[i+1] <= {frac_r[i][LOG2_FRAC-2:0], hit};
      end
    end
  end

  assign out_tag  = tag_r[LOG2_FRAC];
  assign out_pos  = pos_r[LOG2_FRAC];
  assign out_frac = frac_r[LOG2_FRAC];

endmodule

FILE: rtl/core/scaled_log10_converter.sv
// Top level of the scaled log10 converter: log2 pipeline, two multiply stages,
// saturation, output register with skid stage and APB register file. Uses sl10c_pkg.
`timescale 1ns / 1ps

// Returns log_scale * log10(sample) + log_offset for each unsigned fixed-point
// sample, one request per clock while in_tready is high. A request passes through
// one normalise stage, 28 squaring stages (one 32x32 multiplier each), a
// log10(2) multiply, a scale multiply, then add, saturate and register.
// A zero sample gives the most negative result with out_tuser[0] set; a clipped
// sum sets out_tuser[1]. in_tready falls only while the skid stage holds a request.
// Write log_scale (0x0) and log_offset (0x4) only while the block is empty.

module scaled_log10_converter
  import sl10c_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input  logic              clk,
  input  logic              rst_n,

  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [31:0]       in_tdata,   // [31:0] sample_value
  input  logic              in_tlast,

  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [31:0]       out_tdata,  // [31:0] log_result
  output logic [1:0]        out_tuser,  // [0] zero_input_flag, [1] overflow_flag
  output logic              out_tlast,

  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [2:0]        cfg_paddr,
  input  logic [31:0]       cfg_pwdata,
  output logic [31:0]       cfg_prdata,
  output logic              cfg_pready
);

  localparam logic [DATA_W-1:0] SCALE_RESET = DATA_W'(64'd10 << FRAC_BITS);

  logic signed [DATA_W-1:0] scale_r;
  logic signed [DATA_W-1:0] offset_r;
  logic                     cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scale_r  <= SCALE_RESET;
      offset_r <= '0;
    end else if (cfg_wr) begin
      case (sl10c_reg_t'(cfg_paddr[2]))
        REG_LOG_SCALE:  scale_r  <= cfg_pwdata;
        REG_LOG_OFFSET: offset_r <= cfg_pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (sl10c_reg_t'(cfg_paddr[2]))
      REG_LOG_SCALE:  cfg_prdata = scale_r;
      REG_LOG_OFFSET: cfg_prdata = offset_r;
      default:        cfg_prdata = '0;
    endcase
  end

  // Pipeline advance and output handoff
  sl10c_res_t out_r, skid_r;
  logic       out_vld_r, skid_vld_r;
  logic       en;

  assign en        = !skid_vld_r;
  assign in_tready = en;

  sl10c_tag_t           in_tag;
  sl10c_tag_t           l2_tag;
  logic [POS_W-1:0]     l2_pos;
  logic [LOG2_FRAC-1:0] l2_frac;

  assign in_tag = '{vld: in_tvalid, zero: (in_tdata == '0), last: in_tlast};

  sl10c_log2_pipe u_log2 (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_tag   (in_tag),
    .in_x     (in_tdata),
    .out_tag  (l2_tag),
    .out_pos  (l2_pos),
    .out_frac (l2_frac)
  );

  // log10 = log2 * log10(2)
  logic [EXP_W-1:0]                   expo;
  logic signed [EXP_W+LOG2_FRAC-1:0]  l2_s;
  logic signed [2*DATA_W-1:0]         prod1_nxt;
  logic signed [2*DATA_W-1:0]         prod1_r;
  sl10c_tag_t                         tag1_r;

  assign expo      = {1'b0, l2_pos} - EXP_W'(FRAC_BITS);
  assign l2_s      = $signed({expo, l2_frac});
  assign prod1_nxt = l2_s * LOG10_OF_2_Q30;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag1_r <= '0;
    end else if (en) begin
      tag1_r <= l2_tag;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prod1_r <= prod1_nxt;
    end
  end

  // scaled = log10 * scale
  logic signed [DATA_W-1:0]   l10;
  logic signed [2*DATA_W-1:0] prod2_nxt;
  logic signed [2*DATA_W-1:0] prod2_r;
  sl10c_tag_t                 tag2_r;

  assign l10       = $signed(prod1_r[DATA_W+29:30]);
  assign prod2_nxt = l10 * scale_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag2_r <= '0;
    end else if (en) begin
      tag2_r <= tag1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prod2_r <= prod2_nxt;
    end
  end

  // Add offset and saturate
  localparam int SC_W = 2*DATA_W - LOG2_FRAC;

  logic signed [SC_W-1:0] scaled;
  logic signed [SC_W:0]   sum;
  sl10c_res_t             res_nxt;

  assign scaled = $signed(prod2_r[2*DATA_W-1:LOG2_FRAC]);
  assign sum    = (SC_W+1)'(scaled) + (SC_W+1)'(offset_r);

  always_comb begin
    res_nxt      = '0;
    res_nxt.last = tag2_r.last;
    if (tag2_r.zero) begin
      res_nxt.data = RESULT_MIN;
      res_nxt.zero = 1'b1;
    end else if (sum > $signed((SC_W+1)'(RESULT_MAX))) begin
      res_nxt.data = RESULT_MAX;
      res_nxt.ovf  = 1'b1;
    end else if (sum < -$signed((SC_W+1)'({1'b0, RESULT_MIN}))) begin
      res_nxt.data = RESULT_MIN;
      res_nxt.ovf  = 1'b1;
    end else begin
      res_nxt.data = sum[DATA_W-1:0];
    end
  end

  // Output register and skid stage
  logic out_free;
  logic push;

  assign out_free = !out_vld_r || out_tready;
  assign push     = en && tag2_r.vld;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r  <= 1'b0;
      skid_vld_r <= 1'b0;
    end else begin
      if (skid_vld_r) begin
        if (out_tready) begin
          skid_vld_r <= 1'b0;
        end
      end else if (push) begin
        if (out_free) begin
          out_vld_r <= 1'b1;
        end else begin
          skid_vld_r <= 1'b1;
        end
      end else if (out_tready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (skid_vld_r) begin
      if (out_tready) begin
        out_r <= skid_r;
      end
    end else if (push) begin
      if (out_free) begin
        out_r <= res_nxt;
      end else begin
        skid_r <= res_nxt;
      end
    end
  end

  assign out_tvalid   = out_vld_r;
  assign out_tdata    = out_r.data;
  assign out_tuser[0] = out_r.zero;
  assign out_tuser[1] = out_r.ovf;
  assign out_tlast    = out_r.last;

  a_skid_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_vld_r |-> out_vld_r)
    else $error("skid stage holds a request while the output register is empty");

  a_skid_fill: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(skid_vld_r) |-> $past(out_vld_r && !out_tready))
    else $error("skid stage filled while the output register could take the request");

  a_zero_result: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && out_r.zero) |-> (out_r.data == RESULT_MIN && !out_r.ovf))
    else $error("zero sample did not give the saturated low result");

  a_ovf_limit: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && out_r.ovf) |-> (out_r.data == RESULT_MAX || out_r.data == RESULT_MIN))
    else $error("clipped result is not at a limit");

endmodule

FILE: dv/tb_scaled_log10_converter.sv
// Self-checking bench for scaled_log10_converter: samples stream in under random
// bursts and stalls, and each result is compared with an in-bench fixed-point predictor.
// Depends on sl10c_pkg and the converter RTL; reads no files.
`timescale 1ns / 1ps

module tb_scaled_log10_converter;
  import sl10c_pkg::*;

  localparam int     FRAC_BITS = 16;
  localparam int     LATENCY   = 32;
  localparam longint SUM_MAX   = 64'sd2147483647;
  localparam longint SUM_MIN   = -64'sd2147483648;

  typedef enum logic [1:0] {
    RDY_ALWAYS,
    RDY_RANDOM,
    RDY_PATTERN,
    RDY_SPARSE
  } rdy_mode_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [31:0] in_tdata;   // [31:0] sample_value
  logic        in_tlast;
  logic        out_tvalid;
  logic        out_tready;
  logic [31:0] out_tdata;  // [31:0] log_result
  logic [1:0]  out_tuser;  // [0] zero_input_flag, [1] overflow_flag
  logic        out_tlast;
  logic        cfg_psel;
  logic        cfg_penable;
  logic        cfg_pwrite;
  logic [2:0]  cfg_paddr;
  logic [31:0] cfg_pwdata;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  logic signed [31:0] cur_scale  = 32'sd655360;
  logic signed [31:0] cur_offset = 32'sd0;
  sl10c_res_t         pending_results[$];
  int                 mismatches    = 0;
  int                 hold_left     = 0;
  int                 burst_left    = 0;
  bit                 sender_steady = 0;

  scaled_log10_converter #(
    .FRAC_BITS(FRAC_BITS)
  ) u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  function automatic sl10c_res_t predict_level(logic [31:0] x, logic last);
    sl10c_res_t r;
    int         p;
    bit [63:0]  m;
    bit [63:0]  sq;
    longint     frac;
    longint     l2;
    longint     l10;
    longint     sum;
    r      = '0;
    r.last = last;
    if (x == 32'd0) begin
      r.data = RESULT_MIN;
      r.zero = 1'b1;
      return r;
    end
    p = 31;
    while (!x[p]) p--;
    m    = 64'(x) << (31 - p);
    frac = 0;
    for (int i = 0; i < LOG2_FRAC; i++) begin
      sq   = (m * m) >> 31;
      frac = frac << 1;
      if (sq >= 64'h1_0000_0000) begin
        frac = frac | 1;
        m    = sq >> 1;
      end else begin
        m = sq;
      end
    end
    l2  = longint'(p - FRAC_BITS) * (longint'(1) << LOG2_FRAC) + frac;
    l10 = (l2 * longint'(LOG10_OF_2_Q30)) >>> 30;
    sum = ((l10 * longint'(cur_scale)) >>> LOG2_FRAC) + longint'(cur_offset);
    if (sum > SUM_MAX) begin
      r.data = RESULT_MAX;
      r.ovf  = 1'b1;
    end else if (sum < SUM_MIN) begin
      r.data = RESULT_MIN;
      r.ovf  = 1'b1;
    end else begin
      r.data = sum[31:0];
    end
    return r;
  endfunction

  function automatic void flag_mismatch(string what, sl10c_res_t want, sl10c_res_t got);
    mismatches++;
    if (mismatches <= 10)
      $display("%s: expected data %h zero %b ovf %b last %b, got data %h zero %b ovf %b last %b",
               what, want.data, want.zero, want.ovf, want.last,
               got.data, got.zero, got.ovf, got.last);
  endfunction

  function automatic logic [31:0] random_sample();
    logic [31:0] x;
    case ($urandom_range(0, 9))
      0:       x = 32'd0;
      1:       x = 32'd1 << $urandom_range(0, 31);
      2:       x = $urandom_range(1, 255);
      3:       x = 32'h0001_0000 + $urandom_range(0, 63) - 32;
      4, 5:    x = $urandom() >> $urandom_range(0, 31);
      default: x = $urandom();
    endcase
    return x;
  endfunction

  function automatic logic [31:0] random_level();
    logic [31:0] v;
    case ($urandom_range(0, 8))
      0:       v = 32'sd655360;
      1:       v = 32'sd1310720;
      2:       v = -32'sd655360;
      3:       v = 32'h7fff_ffff;
      4:       v = 32'h8000_0000;
      5:       v = 32'd0;
      6:       v = $urandom_range(0, 1 << 24);
      7:       v = -$urandom_range(0, 1 << 24);
      default: v = $urandom();
    endcase
    return v;
  endfunction

  // Checker: compare each accepted result with the oldest prediction.
  always @(posedge clk) begin
    sl10c_res_t got;
    sl10c_res_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got.data = out_tdata;
      got.zero = out_tuser[0];
      got.ovf  = out_tuser[1];
      got.last = out_tlast;
      if (pending_results.size() == 0) begin
        flag_mismatch("unexpected result", '0, got);
      end else begin
        want = pending_results.pop_front();
        if (got !== want) flag_mismatch("result", want, got);
      end
    end
  end

  // Receiver: a stall pattern picked at random drives out_tready; a hold request overrides it.
  initial begin
    int        tick;
    rdy_mode_t mode;
    tick       = 0;
    mode       = RDY_ALWAYS;
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      tick++;
      if (tick % 64 == 0) mode = rdy_mode_t'($urandom_range(0, 3));
      if (hold_left > 0) begin
        hold_left--;
        out_tready = 1'b0;
      end else begin
        case (mode)
          RDY_ALWAYS:  out_tready = 1'b1;
          RDY_RANDOM:  out_tready = $urandom_range(0, 1);
          RDY_PATTERN: out_tready = (tick % 4) != 0;
          default:     out_tready = (tick % 4) == 0;
        endcase
      end
    end
  end

  task automatic send_sample(logic [31:0] x, logic last);
    int gap;
    gap = 0;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      if (!sender_steady) gap = $urandom_range(1, 6);
    end
    burst_left--;
    @(negedge clk);
    if (gap > 0) begin
      in_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tdata  = x;
    in_tlast  = last;
    do @(posedge clk); while (!in_tready);
    pending_results.push_back(predict_level(x, last));
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_tvalid = 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
  endtask

  task automatic write_reg(sl10c_reg_t which, logic [31:0] value);
    sl10c_res_t want_r;
    sl10c_res_t got_r;
    @(negedge clk);
    cfg_psel    = 1'b1;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b1;
    cfg_paddr   = {which, 2'b00};
    cfg_pwdata  = value;
    @(negedge clk);
    cfg_penable = 1'b1;
    do @(posedge clk); while (!cfg_pready);
    @(negedge clk);
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b0;
    @(negedge clk);
    cfg_penable = 1'b1;
    do @(posedge clk); while (!cfg_pready);
    want_r      = '0;
    want_r.data = value;
    got_r       = '0;
    got_r.data  = cfg_prdata;
    if (got_r !== want_r) flag_mismatch("register readback", want_r, got_r);
    @(negedge clk);
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
  endtask

  task automatic set_levels(logic [31:0] scale, logic [31:0] offset);
    wait_drained();
    repeat (4) @(negedge clk);
    write_reg(REG_LOG_SCALE, scale);
    cur_scale = scale;
    write_reg(REG_LOG_OFFSET, offset);
    cur_offset = offset;
  endtask

  task automatic test_directed();
    send_sample(32'd0, 1'b1);
    send_sample(32'd1, 1'b0);
    send_sample(32'hffff_ffff, 1'b1);
    send_sample(32'h0001_0000, 1'b0);
    send_sample(32'h8000_0000, 1'b0);
    send_sample(32'h0000_8000, 1'b1);
    send_sample(32'h000a_0000, 1'b0);
    send_sample(32'h00ff_ffff, 1'b1);
  endtask

  task automatic test_saturation();
    set_levels(32'h7fff_ffff, 32'h7fff_ffff);
    send_sample(32'hffff_ffff, 1'b0);
    send_sample(32'h0001_0000, 1'b1);
    send_sample(32'd1, 1'b0);
    send_sample(32'd0, 1'b1);
    set_levels(32'h8000_0000, 32'h8000_0000);
    send_sample(32'd1, 1'b1);
    send_sample(32'hffff_ffff, 1'b0);
    send_sample(32'h0001_0000, 1'b0);
    send_sample(32'd0, 1'b1);
    set_levels(32'd0, $urandom());
    send_sample($urandom(), 1'b0);
    send_sample(32'd0, 1'b1);
  endtask

  task automatic test_register_sweep();
    for (int phase = 0; phase < 6; phase++) begin
      if (phase == 0) set_levels(32'sd655360, 32'd0);
      else set_levels(random_level(), random_level());
      sender_steady = (phase % 3) == 0;
      repeat (200) send_sample(random_sample(), $urandom_range(0, 1));
    end
    sender_steady = 1'b0;
  endtask

  task automatic test_backpressure();
    set_levels(32'sd1310720, $urandom_range(0, 1 << 20));
    sender_steady = 1'b1;
    hold_left     = 300;
    repeat (120) send_sample(random_sample(), $urandom_range(0, 1));
    wait_drained();
    sender_steady = 1'b0;
    repeat (20) send_sample(random_sample(), $urandom_range(0, 1));
  endtask

  initial begin
    rst_n       = 1'b0;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    in_tlast    = 1'b0;
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b0;
    cfg_paddr   = '0;
    cfg_pwdata  = '0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    test_directed();
    test_saturation();
    test_register_sweep();
    test_backpressure();
    wait_drained();
    repeat (LATENCY + 8) @(posedge clk);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
